/* sv/fsc_pkg.sv */
package fsc_pkg;

    // Lane layout of one plane word: nx, ny, nz, d from the top down
    localparam int LANE_W       = 16;
    localparam int LANES        = 4;
    localparam int PLANE_SLOTS  = 6;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = LANE_W * LANES;
    localparam int FIELD_W      = 16;
    localparam int FRAC_BITS    = 8;

    localparam int NUM_PLANES_DEF = 6;
    localparam int COEF_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_INSIDE    = 2'd2
    } verdict_t;

    typedef struct packed {
        logic     valid;
        verdict_t verdict;
    } result_t;

endpackage

/* sv/fsc_plane_regs.sv */
module fsc_plane_regs #(
    parameter int NUM_PLANES = fsc_pkg::NUM_PLANES_DEF,
    parameter int COEF_WIDTH = fsc_pkg::COEF_WIDTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       wr_en,
    input  logic [fsc_pkg::CFG_INDEX_W-1:0]            wr_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]             wr_data,
    output logic [NUM_PLANES-1:0][4*COEF_WIDTH-1:0]    planes
);
    import fsc_pkg::*;

    logic [NUM_PLANES-1:0][4*COEF_WIDTH-1:0] plane_reg;
    logic [NUM_PLANES-1:0][4*COEF_WIDTH-1:0] plane_next;
    logic [4*COEF_WIDTH-1:0]                 packed_word;

    // Keep only the low COEF_WIDTH bits of each 16-bit lane
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            packed_word[k*COEF_WIDTH +: COEF_WIDTH] = wr_data[k*LANE_W +: COEF_WIDTH];
        end
    end

    always_comb
    begin
        plane_next = plane_reg;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            if (wr_en && (wr_index == CFG_INDEX_W'(i)))
            begin
                plane_next[i] = packed_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

    assign planes = plane_reg;

endmodule

/* sv/fsc_plane_dist.sv */
module fsc_plane_dist #(
    parameter int COEF_WIDTH = fsc_pkg::COEF_WIDTH_DEF,
    parameter int DIST_W     = COEF_WIDTH + fsc_pkg::FIELD_W + 2
) (
    input  logic                                 clk,
    input  logic [4*COEF_WIDTH-1:0]              plane,
    input  logic signed [fsc_pkg::FIELD_W-1:0]   cx,
    input  logic signed [fsc_pkg::FIELD_W-1:0]   cy,
    input  logic signed [fsc_pkg::FIELD_W-1:0]   cz,
    output logic signed [DIST_W-1:0]             distance
);
    import fsc_pkg::*;

    localparam int PROD_W = COEF_WIDTH + FIELD_W;

    logic signed [COEF_WIDTH-1:0] nx, ny, nz, dc;
    logic signed [PROD_W-1:0]     px_next, py_next, pz_next;
    logic signed [PROD_W-1:0]     px_reg, py_reg, pz_reg;
    logic signed [COEF_WIDTH-1:0] d_reg;
    logic signed [DIST_W-1:0]     dist_next, dist_reg;

    assign nx = $signed(plane[4*COEF_WIDTH-1:3*COEF_WIDTH]);
    assign ny = $signed(plane[3*COEF_WIDTH-1:2*COEF_WIDTH]);
    assign nz = $signed(plane[2*COEF_WIDTH-1:COEF_WIDTH]);
    assign dc = $signed(plane[COEF_WIDTH-1:0]);

    assign px_next = PROD_W'(nx) * PROD_W'(cx);
    assign py_next = PROD_W'(ny) * PROD_W'(cy);
    assign pz_next = PROD_W'(nz) * PROD_W'(cz);

    // Add the three products and d moved up to Q16.16
    assign dist_next = DIST_W'(px_reg) + DIST_W'(py_reg) + DIST_W'(pz_reg)
                     + DIST_W'($signed({d_reg, {FRAC_BITS{1'b0}}}));

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        d_reg    <= dc;
        dist_reg <= dist_next;
    end

    assign distance = dist_reg;

endmodule

/* sv/fsc_classify.sv */
module fsc_classify #(
    parameter int NUM_PLANES = fsc_pkg::NUM_PLANES_DEF,
    parameter int DIST_W     = fsc_pkg::COEF_WIDTH_DEF + fsc_pkg::FIELD_W + 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [NUM_PLANES-1:0][DIST_W-1:0]   dists,
    input  logic [fsc_pkg::FIELD_W-1:0]         radius,
    output fsc_pkg::result_t                    result
);
    import fsc_pkg::*;

    logic signed [DIST_W-1:0] rad_pos, rad_neg;
    logic [NUM_PLANES-1:0]    out_next, str_next;
    logic [NUM_PLANES-1:0]    out_reg, str_reg;
    logic                     flag_valid_reg;
    result_t                  result_next, result_reg;

    assign rad_pos = $signed(DIST_W'({radius, {FRAC_BITS{1'b0}}}));
    assign rad_neg = -rad_pos;

    always_comb
    begin
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            out_next[i] = $signed(dists[i]) < rad_neg;
            str_next[i] = ($signed(dists[i]) > rad_neg) && ($signed(dists[i]) < rad_pos);
        end
    end

    // Outside on any plane wins over straddling
    always_comb
    begin
        result_next.valid = flag_valid_reg;
        if (|out_reg)
        begin
            result_next.verdict = VERDICT_OUTSIDE;
        end
        else if (|str_reg)
        begin
            result_next.verdict = VERDICT_INTERSECT;
        end
        else
        begin
            result_next.verdict = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        str_reg <= str_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_valid_reg <= 1'b0;
            result_reg     <= '{valid: 1'b0, verdict: VERDICT_OUTSIDE};
        end
        else
        begin
            flag_valid_reg <= in_valid;
            result_reg     <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* sv/frustum_sphere_cull.sv */
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ----------------------------------------
// item      in         start && !busy         center_x, center_y, center_z, sphere_radius
// config    in         cfg_valid && cfg_ready cfg_index, cfg_data (one plane word)
// result    out        done (one-cycle pulse) verdict
//
// Takes one item every cycle; busy never rises and cfg_ready stays high.
// done pulses once the item has passed the input register, one
// multiplier stage per plane, one adder stage, one compare stage, one verdict stage.
// rst_n clears all valid bits and every plane word to zero.
// The receiver cannot stall, so the pipeline advances on every clock.
module frustum_sphere_cull #(
    parameter int NUM_PLANES = fsc_pkg::NUM_PLANES_DEF,
    parameter int COEF_WIDTH = fsc_pkg::COEF_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [fsc_pkg::FIELD_W-1:0]   center_x,
    input  logic signed [fsc_pkg::FIELD_W-1:0]   center_y,
    input  logic signed [fsc_pkg::FIELD_W-1:0]   center_z,
    input  logic [fsc_pkg::FIELD_W-1:0]          sphere_radius,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fsc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 done,
    output fsc_pkg::verdict_t                    verdict
);
    import fsc_pkg::*;

    // Distance width: one product plus two bits of growth for the four-term sum
    localparam int DIST_W = COEF_WIDTH + FIELD_W + 2;

    logic                                    accept;
    logic [NUM_PLANES-1:0][4*COEF_WIDTH-1:0] planes;
    logic [NUM_PLANES-1:0][DIST_W-1:0]       dists;
    result_t                                 result;

    // Input stage and radius delay line; radius rides alongside the two
    // distance stages so it lines up with the compare stage.
    logic signed [FIELD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [FIELD_W-1:0]        rad0_reg, rad1_reg, rad2_reg;
    logic                      v0_reg, v1_reg, v2_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk)
    begin
        cx_reg   <= center_x;
        cy_reg   <= center_y;
        cz_reg   <= center_z;
        rad0_reg <= sphere_radius;
        rad1_reg <= rad0_reg;
        rad2_reg <= rad1_reg;
    end

    // Valid bits march with the word through the distance stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Plane words; writes to slots past NUM_PLANES are dropped
    fsc_plane_regs #(
        .NUM_PLANES (NUM_PLANES),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_plane_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .planes   (planes)
    );

    // One distance lane per plane: multiply, then sum
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        fsc_plane_dist #(
            .COEF_WIDTH (COEF_WIDTH),
            .DIST_W     (DIST_W)
        ) u_dist (
            .clk      (clk),
            .plane    (planes[p]),
            .cx       (cx_reg),
            .cy       (cy_reg),
            .cz       (cz_reg),
            .distance (dists[p])
        );
    end

    // Compare each distance against the radius, then fold into one verdict
    fsc_classify #(
        .NUM_PLANES (NUM_PLANES),
        .DIST_W     (DIST_W)
    ) u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v2_reg),
        .dists    (dists),
        .radius   (rad2_reg),
        .result   (result)
    );

    assign done    = result.valid;
    assign verdict = result.verdict;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import fsc_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int LATENCY         = 5;
    localparam int STALL_LIMIT     = 1000;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int ACTIVE_PLANES   = NUM_PLANES_DEF;
    localparam int COEF_W          = COEF_WIDTH_DEF;

    // Plane register indexes; the two spare codes address no register
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FAR      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    // Unit normals in Q8.8
    localparam logic [LANE_W-1:0] Q_ONE     = 16'h0100;
    localparam logic [LANE_W-1:0] Q_NEG_ONE = 16'hFF00;
    localparam logic [LANE_W-1:0] Q_ZERO    = 16'h0000;

    typedef enum int {
        FRUSTUM_BOX,
        FRUSTUM_TILTED,
        FRUSTUM_EXTREME,
        FRUSTUM_RANDOM
    } frustum_kind_t;

    // Scoreboard: a shadow of the plane registers, the verdict predictor and
    // the queue of verdicts still owed by the block.
    class cull_scoreboard_t;
        logic [CFG_DATA_W-1:0] planes [PLANE_SLOTS];
        verdict_t owed_q [$];
        int errors;
        int items_seen;
        int tally [3];

        function new();
            foreach (planes[i]) planes[i] = '0;
            foreach (tally[i]) tally[i] = 0;
            errors = 0;
            items_seen = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void load_plane(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
            if (idx < PLANE_SLOTS)
                planes[idx] = word;
        endfunction

        // Signed coefficient of one lane, sign-extended from COEF_W bits
        function longint coef(logic [CFG_DATA_W-1:0] word, int slot);
            logic [LANE_W-1:0] raw;
            longint v;
            raw = word[slot*LANE_W +: LANE_W];
            v = longint'({{(64-LANE_W){1'b0}}, raw});
            v = (v <<< (64 - COEF_W)) >>> (64 - COEF_W);
            return v;
        endfunction

        // Outside wins over intersect: every plane is checked for outside first
        function verdict_t classify(logic [FIELD_W-1:0] cx, logic [FIELD_W-1:0] cy,
                                    logic [FIELD_W-1:0] cz, logic [FIELD_W-1:0] radius);
            longint plane_d [PLANE_SLOTS];
            longint sx;
            longint sy;
            longint sz;
            longint reach;
            longint mag;
            bit beyond;
            bit straddle;
            int p;
            sx = longint'($signed(cx));
            sy = longint'($signed(cy));
            sz = longint'($signed(cz));
            reach = longint'({{(64-FIELD_W){1'b0}}, radius}) <<< FRAC_BITS;
            beyond = 1'b0;
            straddle = 1'b0;
            for (p = 0; p < ACTIVE_PLANES; p++) begin
                plane_d[p] = coef(planes[p], 3) * sx + coef(planes[p], 2) * sy
                           + coef(planes[p], 1) * sz + (coef(planes[p], 0) <<< FRAC_BITS);
                if (plane_d[p] < -reach)
                    beyond = 1'b1;
            end
            for (p = 0; p < ACTIVE_PLANES; p++) begin
                mag = (plane_d[p] < 0) ? -plane_d[p] : plane_d[p];
                if (mag < reach)
                    straddle = 1'b1;
            end
            if (beyond)
                return VERDICT_OUTSIDE;
            if (straddle)
                return VERDICT_INTERSECT;
            return VERDICT_INSIDE;
        endfunction

        function void note_item(logic [FIELD_W-1:0] cx, logic [FIELD_W-1:0] cy,
                                logic [FIELD_W-1:0] cz, logic [FIELD_W-1:0] radius);
            owed_q.push_back(classify(cx, cy, cz, radius));
            items_seen++;
        endfunction

        task check_verdict(verdict_t got);
            verdict_t want;
            if (owed_q.size() == 0) begin
                report($sformatf("verdict %0d with no item outstanding", got));
            end
            else begin
                want = owed_q.pop_front();
                if (got !== want)
                    report($sformatf("verdict %0d, predicted %0d", got, want));
                else
                    tally[int'(got)]++;
            end
        endtask

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [FIELD_W-1:0]      center_x = '0;
    logic [FIELD_W-1:0]      center_y = '0;
    logic [FIELD_W-1:0]      center_z = '0;
    logic [FIELD_W-1:0]      sphere_radius = '0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    done;
    verdict_t                verdict;

    cull_scoreboard_t sb;

    // Plane words staged for the next configuration pass, and the box bounds
    // (Q8.8, per axis) that steer item centers toward the interesting region.
    logic [CFG_DATA_W-1:0] frustum [PLANE_SLOTS];
    int box_lo [3];
    int box_hi [3];
    int settings_count;
    int quiet_cycles;

    frustum_sphere_cull #(
        .NUM_PLANES (ACTIVE_PLANES),
        .COEF_WIDTH (COEF_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .verdict       (verdict)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Monitor: every handshake is taken from values sampled at the rising edge.
    // Check the result first, then apply a config word, then note a new item.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_verdict(verdict);
            if (cfg_valid && cfg_ready)
                sb.load_plane(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_item(center_x, center_y, center_z, sphere_radius);
        end
    end

    // Watchdog: count cycles in which no word moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no traffic for %0d cycles, %0d verdicts owed",
                         STALL_LIMIT, sb.pending());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [FIELD_W-1:0] clamp_q(int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[FIELD_W-1:0];
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_plane(logic [LANE_W-1:0] nx,
                                                         logic [LANE_W-1:0] ny,
                                                         logic [LANE_W-1:0] nz,
                                                         logic [LANE_W-1:0] d);
        return {nx, ny, nz, d};
    endfunction

    // A coordinate somewhere within the box widened by 4.0 on each side
    function automatic int near_axis(int a);
        return box_lo[a] - 1024 + int'($urandom_range(0, box_hi[a] - box_lo[a] + 2048));
    endfunction

    // Hold start low for a burst of cycles; scramble the payload meanwhile
    task automatic idle_sender(int cycles);
        start         <= 1'b0;
        center_x      <= FIELD_W'($urandom);
        center_y      <= FIELD_W'($urandom);
        center_z      <= FIELD_W'($urandom);
        sphere_radius <= FIELD_W'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Present one item and wait for the edge that takes it. start stays high
    // so the next call can follow back to back.
    task automatic send_item(logic [FIELD_W-1:0] cx, logic [FIELD_W-1:0] cy,
                             logic [FIELD_W-1:0] cz, logic [FIELD_W-1:0] radius);
        start         <= 1'b1;
        center_x      <= cx;
        center_y      <= cy;
        center_z      <= cz;
        sphere_radius <= radius;
        do @(posedge clk); while (busy);
    endtask

    // Drop start and hold until every owed verdict has come back. The first
    // edge lets the monitor note an item taken on the edge just passed.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_word(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write all six staged planes back to back; with spares, also hit the two
    // unused indexes, which the block must drop.
    task automatic program_frustum(bit spares);
        int i;
        if (spares)
            write_word(REG_SPARE_LO, {$urandom, $urandom});
        for (i = 0; i < PLANE_SLOTS; i++)
            write_word(i[CFG_INDEX_W-1:0], frustum[i]);
        if (spares)
            write_word(REG_SPARE_HI, '1);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // Axis-aligned box: each plane faces inward with a unit normal
    task automatic build_box();
        frustum[REG_LEFT]   = pack_plane(Q_ONE, Q_ZERO, Q_ZERO, clamp_q(-box_lo[0]));
        frustum[REG_RIGHT]  = pack_plane(Q_NEG_ONE, Q_ZERO, Q_ZERO, clamp_q(box_hi[0]));
        frustum[REG_BOTTOM] = pack_plane(Q_ZERO, Q_ONE, Q_ZERO, clamp_q(-box_lo[1]));
        frustum[REG_TOP]    = pack_plane(Q_ZERO, Q_NEG_ONE, Q_ZERO, clamp_q(box_hi[1]));
        frustum[REG_NEAR]   = pack_plane(Q_ZERO, Q_ZERO, Q_ONE, clamp_q(-box_lo[2]));
        frustum[REG_FAR]    = pack_plane(Q_ZERO, Q_ZERO, Q_NEG_ONE, clamp_q(box_hi[2]));
    endtask

    task automatic build_frustum(frustum_kind_t kind);
        int i;
        for (i = 0; i < 3; i++) begin
            box_lo[i] = -int'($urandom_range(0, 6000));
            box_hi[i] = int'($urandom_range(0, 6000));
        end
        case (kind)
            FRUSTUM_BOX: build_box();
            FRUSTUM_TILTED:
                // Small random normals, offsets within +/-8.0
                for (i = 0; i < PLANE_SLOTS; i++)
                    frustum[i] = pack_plane(clamp_q(int'($urandom_range(0, 512)) - 256),
                                            clamp_q(int'($urandom_range(0, 512)) - 256),
                                            clamp_q(int'($urandom_range(0, 512)) - 256),
                                            clamp_q(int'($urandom_range(0, 4096)) - 2048));
            FRUSTUM_EXTREME:
                for (i = 0; i < PLANE_SLOTS; i++)
                    case ($urandom_range(0, 4))
                        0: frustum[i] = '0;
                        1: frustum[i] = '1;
                        2: frustum[i] = 64'h8000_8000_8000_8000;
                        3: frustum[i] = 64'h7FFF_7FFF_7FFF_7FFF;
                        default: frustum[i] = 64'h8000_7FFF_8000_7FFF;
                    endcase
            default:
                for (i = 0; i < PLANE_SLOTS; i++)
                    frustum[i] = {$urandom, $urandom};
        endcase
    endtask

    // Mostly spheres near the box, plus points, raw noise, extreme radii and
    // centers sitting on a face
    task automatic make_item(output logic [FIELD_W-1:0] cx, output logic [FIELD_W-1:0] cy,
                             output logic [FIELD_W-1:0] cz, output logic [FIELD_W-1:0] radius);
        int mode;
        int axis;
        int face_pos;
        mode   = $urandom_range(0, 9);
        cx     = clamp_q(near_axis(0));
        cy     = clamp_q(near_axis(1));
        cz     = clamp_q(near_axis(2));
        radius = FIELD_W'($urandom_range(0, 1536));
        case (mode)
            6: radius = '0;
            7:
            begin
                cx     = FIELD_W'($urandom);
                cy     = FIELD_W'($urandom);
                cz     = FIELD_W'($urandom);
                radius = FIELD_W'($urandom);
            end
            8:
                case ($urandom_range(0, 3))
                    0: radius = '0;
                    1: radius = 16'h0001;
                    2: radius = 16'hFFFF;
                    default: radius = 16'hFF00;
                endcase
            9:
            begin
                axis     = $urandom_range(0, 2);
                face_pos = ($urandom_range(0, 1) != 0) ? box_hi[axis] : box_lo[axis];
                face_pos = face_pos + int'($urandom_range(0, 64)) - 32;
                radius   = FIELD_W'($urandom_range(0, 64));
                case (axis)
                    0: cx = clamp_q(face_pos);
                    1: cy = clamp_q(face_pos);
                    default: cz = clamp_q(face_pos);
                endcase
            end
            default: ;
        endcase
    endtask

    initial
    begin
        logic [FIELD_W-1:0] cx;
        logic [FIELD_W-1:0] cy;
        logic [FIELD_W-1:0] cz;
        logic [FIELD_W-1:0] radius;
        int phase;
        int n;
        bit idle_on;
        frustum_kind_t kind;

        sb = new();
        settings_count = 1;
        quiet_cycles = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Planes still all zero from reset: every distance is zero, so a point
        // lands inside and any nonzero radius straddles.
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(16'h8000, 16'h7FFF, 16'h8000, 16'h0001);
        send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h0000);

        // Unit box +/-1.0 on every axis; spare indexes written with junk
        wait_drained();
        for (n = 0; n < 3; n++) begin
            box_lo[n] = -256;
            box_hi[n] = 256;
        end
        build_box();
        program_frustum(1'b1);
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0080);
        // radius exactly equal to the face distance counts as inside
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0100);
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0101);
        // center 1.0 beyond the right face: outside unless the radius reaches it
        send_item(16'h0200, 16'h0000, 16'h0000, 16'h0000);
        send_item(16'h0200, 16'h0000, 16'h0000, 16'h0100);
        send_item(16'h0200, 16'h0000, 16'h0000, 16'h00FF);
        send_item(16'h0200, 16'h0000, 16'h0000, 16'h0101);
        // straddles the left plane but lies far beyond the far plane: outside
        send_item(16'hFF38, 16'h0000, 16'h03E8, 16'h0064);
        // point sitting on a face
        send_item(16'h0100, 16'h0000, 16'h0000, 16'h0000);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h0000);
        send_item(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);

        // Coefficient extremes, one plane each
        wait_drained();
        frustum[REG_LEFT]   = 64'h8000_8000_8000_8000;
        frustum[REG_RIGHT]  = 64'h7FFF_7FFF_7FFF_7FFF;
        frustum[REG_BOTTOM] = '1;
        frustum[REG_TOP]    = '0;
        frustum[REG_NEAR]   = 64'h0001_0001_0001_0001;
        frustum[REG_FAR]    = 64'h8000_7FFF_0000_FFFF;
        program_frustum(1'b0);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // Random phases; each one drains, reprograms, then streams items. Box
        // settings dominate since they yield all three verdicts.
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            wait_drained();
            case (phase)
                1, 4: kind = FRUSTUM_TILTED;
                3: kind = FRUSTUM_EXTREME;
                5: kind = FRUSTUM_RANDOM;
                default: kind = FRUSTUM_BOX;
            endcase
            build_frustum(kind);
            program_frustum(phase % 2 == 0);
            // some phases stream with no gaps, and so does the last one
            idle_on = (phase % 3 != 2) && (phase != RAND_PHASES - 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (idle_on && $urandom_range(0, 5) == 0)
                    idle_sender($urandom_range(1, 14));
                make_item(cx, cy, cz, radius);
                send_item(cx, cy, cz, radius);
            end
        end

        // Drain, then give a stray pulse time to show up
        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d verdicts never arrived", sb.pending()));

        $display("Run covered %0d items over %0d plane settings, including spare indexes",
                 sb.items_seen, settings_count);
        $display("Verdicts seen: outside %0d, intersect %0d, inside %0d; mismatches %0d",
                 sb.tally[VERDICT_OUTSIDE], sb.tally[VERDICT_INTERSECT],
                 sb.tally[VERDICT_INSIDE], sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* frustum_sphere_cull.f */
sv/fsc_pkg.sv
sv/fsc_plane_regs.sv
sv/fsc_plane_dist.sv
sv/fsc_classify.sv
sv/frustum_sphere_cull.sv
tb/sv/tb.sv
